// ----- hw/rtl/largest_empty_square_finder_macros.svh -----
// ----------------------------------------------------------------------------
// Largest empty square finder assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LARGEST_EMPTY_SQUARE_FINDER_MACROS_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_MACROS_SVH

`ifndef SYNTH
`define LESF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lesf assertion failed");
`define LESF_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("lesf forbidden condition seen");
`else
`define LESF_ASSERT(label, clk, rst_n, prop)
`define LESF_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- hw/rtl/lesf_pkg.sv -----
// ----------------------------------------------------------------------------
// Largest empty square finder package
// Sizes and widths shared by the square finder RTL.
// ----------------------------------------------------------------------------
package lesf_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;

	localparam int SIZE_W = 11;
	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int ROW_W  = $clog2(MAX_ROWS);

	localparam logic [SIZE_W-1:0] COLUMNS_RESET = SIZE_W'(MAX_COLUMNS);

	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;

	function automatic size_t min3(input size_t a, input size_t b, input size_t c);
		size_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

endpackage

// ----- hw/rtl/largest_empty_square_finder.sv -----
// ----------------------------------------------------------------------------
// Largest empty square finder
// Streams a grid of cells and reports the largest all-free square.
// ----------------------------------------------------------------------------
// Usage:
//   Cells arrive in row-major order on the in channel (cell_free, last_cell),
//   one word per cycle with valid/ready. The cfg channel sets the row width
//   (columns); write it between grids. Zero acts as one, values above 1024
//   act as 1024.
//   Each cell is registered, then its square size is formed from the left,
//   upper and upper-left sizes; the upper size comes from a 1024-entry line
//   buffer read at acceptance. One cell per cycle sustained while in_ready is high.
//   On the cell marked last, best_size, corner_row and corner_col are loaded
//   into the out register when that cell leaves the stage register (out_valid
//   rises then), and the grid state clears for the next grid.
//   A waiting result does not block input; only a second last cell stalls
//   in_ready while the out register is still full.
//   Reset clears all control state and sets columns to 1024; the line buffer
//   is tracked by a fill count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "largest_empty_square_finder_macros.svh"

module largest_empty_square_finder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [lesf_pkg::SIZE_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cell_free,
	input  logic                  last_cell,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [lesf_pkg::SIZE_W-1:0] best_size,
	output logic [lesf_pkg::ROW_W-1:0]  corner_row,
	output logic [lesf_pkg::COL_W-1:0]  corner_col
);
	import lesf_pkg::*;

	size_t columns_q;
	col_t  col_q;
	row_t  row_q;

	logic  s1_valid;
	logic  last_s1;
	logic  free_s1;
	logic  end_s1;
	logic  byp_s1;
	col_t  col_s1;
	row_t  row_s1;
	size_t up_rd_s1;
	size_t fwd_s1;

	size_t left_q;
	size_t diag_q;
	size_t fill_q;
	size_t best_size_q;
	row_t  corner_row_q;
	col_t  corner_col_q;

	logic  out_valid_q;
	size_t out_size_q;
	row_t  out_row_q;
	col_t  out_col_q;

	size_t line_mem [MAX_COLUMNS];

	size_t eff_width;
	logic  end_row;
	logic  in_fire;
	logic  s1_go;
	size_t up;
	size_t left;
	size_t diag;
	size_t size;
	logic  upd;
	size_t back;
	size_t nxt_best_size;
	row_t  nxt_corner_row;
	col_t  nxt_corner_col;

	assign cfg_ready = 1'b1;
	assign in_ready  = !s1_valid || !last_s1 || !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign s1_go     = s1_valid && in_ready;

	always_comb begin
		if (columns_q == '0) begin
			eff_width = SIZE_W'(1);
		end else if (columns_q > SIZE_W'(MAX_COLUMNS)) begin
			eff_width = SIZE_W'(MAX_COLUMNS);
		end else begin
			eff_width = columns_q;
		end
		end_row = ({1'b0, col_q} + SIZE_W'(1)) >= eff_width;
	end

	always_comb begin
		up   = '0;
		left = '0;
		diag = '0;
		if (row_s1 != '0 && {1'b0, col_s1} < fill_q) begin
			up = byp_s1 ? fwd_s1 : up_rd_s1;
		end
		if (col_s1 != '0) begin
			left = left_q;
			diag = (row_s1 != '0) ? diag_q : '0;
		end
		size = free_s1 ? SIZE_W'(min3(left, up, diag) + SIZE_W'(1)) : '0;

		upd  = size > best_size_q;
		back = size - SIZE_W'(1);
		nxt_best_size  = best_size_q;
		nxt_corner_row = corner_row_q;
		nxt_corner_col = corner_col_q;
		if (upd) begin
			nxt_best_size  = size;
			nxt_corner_col = (back > {1'b0, col_s1}) ? '0 : col_s1 - back[COL_W-1:0];
			nxt_corner_row = row_s1 - back[ROW_W-1:0];
		end
	end

	// line buffer and stage payload
	always_ff @(posedge clk) begin
		if (s1_go) begin
			line_mem[col_s1] <= size;
		end
		if (in_fire) begin
			up_rd_s1 <= line_mem[col_q];
			free_s1  <= cell_free;
			last_s1  <= last_cell;
			end_s1   <= end_row;
			col_s1   <= col_q;
			row_s1   <= row_q;
			byp_s1   <= s1_go && (col_s1 == col_q);
			fwd_s1   <= size;
		end
		if (s1_go && last_s1) begin
			out_size_q <= nxt_best_size;
			out_row_q  <= nxt_corner_row;
			out_col_q  <= nxt_corner_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q    <= COLUMNS_RESET;
			col_q        <= '0;
			row_q        <= '0;
			s1_valid     <= 1'b0;
			left_q       <= '0;
			diag_q       <= '0;
			fill_q       <= '0;
			best_size_q  <= '0;
			corner_row_q <= '0;
			corner_col_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				columns_q <= cfg_data;
			end

			// advance position
			if (in_fire) begin
				if (last_cell) begin
					col_q <= '0;
					row_q <= '0;
				end else if (end_row) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (in_ready) begin
				s1_valid <= in_valid;
			end

			if (s1_go) begin
				if (last_s1) begin
					left_q       <= '0;
					diag_q       <= '0;
					fill_q       <= '0;
					best_size_q  <= '0;
					corner_row_q <= '0;
					corner_col_q <= '0;
				end else begin
					left_q       <= end_s1 ? '0 : size;
					diag_q       <= end_s1 ? '0 : up;
					best_size_q  <= nxt_best_size;
					corner_row_q <= nxt_corner_row;
					corner_col_q <= nxt_corner_col;
					if ({1'b0, col_s1} >= fill_q) begin
						fill_q <= {1'b0, col_s1} + SIZE_W'(1);
					end
				end
			end

			if (s1_go && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign best_size  = out_size_q;
	assign corner_row = out_row_q;
	assign corner_col = out_col_q;

	`LESF_ASSERT(a_clear_after_last, clk, arst_n, s1_go && last_s1 |=> best_size_q == '0 && fill_q == '0)
	`LESF_ASSERT(a_stall_cause, clk, arst_n, !in_ready |-> out_valid_q && s1_valid && last_s1)
	`LESF_ASSERT(a_out_from_last, clk, arst_n, $rose(out_valid_q) |-> $past(s1_go && last_s1))
	`LESF_ASSERT_NEVER(a_best_without_fill, clk, arst_n, best_size_q != '0 && fill_q == '0)

endmodule
